### rtl/mmd_pkg.sv
// mmd_pkg: shared types and constants of the message deframer
// request structs, role and status codes, msgpack tag bytes; no dependencies

package mmd_pkg;

    // one input request: a raw message byte and its end flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // one output request: the echoed byte, its role and the end-of-message summary
    typedef struct packed {
        logic [7:0]  byte_value;
        logic [3:0]  byte_role;
        logic        end_of_message;
        logic [1:0]  status;
        logic [15:0] payload_length;
        logic        map_no_entries;
        logic        stamp_present;
    } t_out_item;

    // stack control from the parser to the skip stack
    typedef struct packed {
        logic push_en;
        logic pop_en;
    } t_stk_ctl;

    typedef logic [3:0] t_role;

    localparam int SKIP_W = 5;

    // byte roles
    localparam t_role ROLE_DEST    = 4'd0;
    localparam t_role ROLE_SRC     = 4'd1;
    localparam t_role ROLE_SIG     = 4'd2;
    localparam t_role ROLE_TS      = 4'd3;
    localparam t_role ROLE_TITLE   = 4'd4;
    localparam t_role ROLE_CONTENT = 4'd5;
    localparam t_role ROLE_STAMP   = 4'd6;
    localparam t_role ROLE_STRUCT  = 4'd7;
    localparam t_role ROLE_TRAIL   = 4'd8;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_TAG   = 2'd2;
    localparam logic [1:0] ST_DEEP  = 2'd3;

    // msgpack tags
    localparam logic [7:0] TAG_FLOAT64 = 8'hCB;
    localparam logic [7:0] TAG_BIN8    = 8'hC4;
    localparam logic [7:0] TAG_BIN16   = 8'hC5;
    localparam logic [7:0] TAG_STR8    = 8'hD9;
    localparam logic [7:0] TAG_NIL     = 8'hC0;
    localparam logic [7:0] TAG_UINT8   = 8'hCC;
    localparam logic [2:0] FIXSTR_HI   = 3'b101;
    localparam logic [3:0] FIXARRAY_HI = 4'h9;
    localparam logic [3:0] FIXMAP_HI   = 4'h8;

    // element counts of the outer array
    localparam logic [2:0] ARRAY_PLAIN      = 3'd4;
    localparam logic [2:0] ARRAY_WITH_STAMP = 3'd5;

endpackage

### rtl/mmd_skip_stack.sv
// mmd_skip_stack: stack of pending object counts for skipped map contents
// one register per level, in-place decrement and pop search; uses mmd_pkg

module mmd_skip_stack
    import mmd_pkg::*;
#(
    parameter int NEST_DEPTH = 8,
    localparam int LW = $clog2(NEST_DEPTH + 1),
    localparam int IW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1
) (
    input  logic              i_clk,
    input  t_stk_ctl          i_ctl,
    input  logic [LW-1:0]     i_level,
    input  logic [SKIP_W-1:0] i_push_value,
    output logic              o_found,
    output logic [IW-1:0]     o_found_idx
);

    logic [SKIP_W-1:0] r_entry [NEST_DEPTH];

    // highest live level whose count does not run out on the next decrement
    always_comb begin
        o_found     = 1'b0;
        o_found_idx = '0;
        for (int k = 0; k < NEST_DEPTH; k++) begin
            if (LW'(k) < i_level && r_entry[k] != SKIP_W'(1)) begin
                o_found     = 1'b1;
                o_found_idx = IW'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NEST_DEPTH; k++) begin
            if (i_ctl.push_en && i_level[IW-1:0] == IW'(k)) begin
                r_entry[k] <= i_push_value;
            end else if (i_ctl.pop_en && o_found_idx == IW'(k)) begin
                r_entry[k] <= r_entry[k] - SKIP_W'(1);
            end
        end
    end

endmodule

### rtl/mmd_parse_core.sv
// mmd_parse_core: parser state and per-byte next-state and result logic
// uses mmd_pkg and mmd_skip_stack

module mmd_parse_core
    import mmd_pkg::*;
#(
    parameter int HASH_BYTES      = 16,
    parameter int SIGNATURE_BYTES = 64,
    parameter int NEST_DEPTH      = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    localparam int LW = $clog2(NEST_DEPTH + 1);
    localparam int IW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam logic [6:0] HASH_LAST = 7'(HASH_BYTES - 1);
    localparam logic [6:0] SIG_LAST  = 7'(SIGNATURE_BYTES - 1);

    typedef enum logic [3:0] {
        PH_DEST, PH_SRC, PH_SIG, PH_ARR, PH_TS_TAG, PH_TS_DATA, PH_BIN_TAG,
        PH_LEN_HI, PH_LEN_LO, PH_BIN_DATA, PH_MAP_HDR, PH_SKIP, PH_DONE, PH_ERROR
    } t_phase;

    t_phase        r_phase,     n_phase;
    logic [6:0]    r_fix_idx,   n_fix_idx;
    t_role         r_role,      n_role;
    logic [15:0]   r_bin_rem,   n_bin_rem;
    logic [7:0]    r_len_hi,    n_len_hi;
    logic [2:0]    r_total,     n_total;
    logic [LW-1:0] r_level,     n_level;
    logic [15:0]   r_count,     n_count;
    logic [1:0]    r_err,       n_err;
    logic          r_map_empty, n_map_empty;
    logic          r_stamp,     n_stamp;

    logic [7:0]        b;
    logic [3:0]        b_hi;
    logic [3:0]        b_lo;
    logic              is_bin;
    t_role             role;
    logic              do_bin;
    logic              start_len;
    logic [15:0]       len_val;
    logic              end_it;
    logic              fin;
    logic              after;
    logic              push;
    logic [SKIP_W-1:0] push_val;
    logic              fail;
    logic [1:0]        fail_code;
    logic              found;
    logic [IW-1:0]     found_idx;
    t_stk_ctl          stk_ctl;
    logic [6:0]        fix_lim;

    assign b      = i_item.data_byte;
    assign b_hi   = b[7:4];
    assign b_lo   = b[3:0];
    assign is_bin = (b == TAG_BIN8) || (b == TAG_STR8) || (b == TAG_BIN16)
                  || (b[7:5] == FIXSTR_HI);
    assign fix_lim = (r_phase == PH_SIG) ? SIG_LAST : HASH_LAST;

    always_comb begin
        n_phase     = r_phase;
        n_fix_idx   = r_fix_idx;
        n_role      = r_role;
        n_bin_rem   = r_bin_rem;
        n_len_hi    = r_len_hi;
        n_total     = r_total;
        n_level     = r_level;
        n_count     = r_count;
        n_err       = r_err;
        n_map_empty = r_map_empty;
        n_stamp     = r_stamp;
        role        = ROLE_STRUCT;
        do_bin      = 1'b0;
        start_len   = 1'b0;
        len_val     = '0;
        end_it      = 1'b0;
        fin         = 1'b0;
        after       = 1'b0;
        push        = 1'b0;
        push_val    = '0;
        fail        = 1'b0;
        fail_code   = ST_TAG;
        stk_ctl     = '0;

        case (r_phase)
            PH_DEST, PH_SRC, PH_SIG: begin
                role      = (r_phase == PH_DEST) ? ROLE_DEST :
                            (r_phase == PH_SRC)  ? ROLE_SRC  : ROLE_SIG;
                n_fix_idx = r_fix_idx + 7'd1;
                if (r_fix_idx == fix_lim) begin
                    n_fix_idx = '0;
                    n_phase   = (r_phase == PH_DEST) ? PH_SRC :
                                (r_phase == PH_SRC)  ? PH_SIG : PH_ARR;
                end
            end
            PH_ARR: begin
                if (b_hi == FIXARRAY_HI
                    && (b_lo == 4'(ARRAY_PLAIN) || b_lo == 4'(ARRAY_WITH_STAMP))) begin
                    n_total = b_lo[2:0];
                    n_phase = PH_TS_TAG;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_TS_TAG: begin
                if (b == TAG_FLOAT64) begin
                    n_phase   = PH_TS_DATA;
                    n_fix_idx = '0;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_TS_DATA: begin
                role      = ROLE_TS;
                n_fix_idx = r_fix_idx + 7'd1;
                if (r_fix_idx == 7'd7) begin
                    n_fix_idx = '0;
                    n_phase   = PH_BIN_TAG;
                    n_role    = ROLE_TITLE;
                end
            end
            PH_BIN_TAG: begin
                if (r_role == ROLE_STAMP && b == TAG_NIL) begin
                    n_phase = PH_DONE;
                end else if (is_bin) begin
                    do_bin = 1'b1;
                    if (r_role == ROLE_STAMP) begin
                        n_stamp = 1'b1;
                    end
                end else begin
                    fail = 1'b1;
                end
            end
            PH_LEN_HI: begin
                n_len_hi = b;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                start_len = 1'b1;
                len_val   = {r_len_hi, b};
            end
            PH_BIN_DATA: begin
                role      = r_role;
                n_bin_rem = r_bin_rem - 16'd1;
                if (r_bin_rem == 16'd1) begin
                    end_it = 1'b1;
                end
            end
            PH_MAP_HDR: begin
                if (b_hi == FIXMAP_HI) begin
                    n_map_empty = (b_lo == 4'd0);
                    if (b_lo == 4'd0) begin
                        after = 1'b1;
                    end else begin
                        push     = 1'b1;
                        push_val = {b_lo, 1'b0};
                    end
                end else begin
                    fail = 1'b1;
                end
            end
            PH_SKIP: begin
                n_role = ROLE_STRUCT;
                if (b == TAG_NIL || !b[7]) begin
                    fin = 1'b1;
                end else if (b == TAG_FLOAT64) begin
                    start_len = 1'b1;
                    len_val   = 16'd8;
                end else if (b == TAG_UINT8) begin
                    start_len = 1'b1;
                    len_val   = 16'd1;
                end else if (b_hi == FIXMAP_HI || b_hi == FIXARRAY_HI) begin
                    // a map holds twice its count of objects
                    if (b_lo == 4'd0) begin
                        fin = 1'b1;
                    end else begin
                        push     = 1'b1;
                        push_val = (b_hi == FIXMAP_HI) ? {b_lo, 1'b0} : {1'b0, b_lo};
                    end
                end else if (is_bin) begin
                    do_bin = 1'b1;
                end else begin
                    fail = 1'b1;
                end
            end
            default: begin
                role = ROLE_TRAIL;
            end
        endcase

        // length header of a bin or str item
        if (do_bin) begin
            if (b == TAG_BIN8 || b == TAG_STR8) begin
                n_len_hi = '0;
                n_phase  = PH_LEN_LO;
            end else if (b == TAG_BIN16) begin
                n_phase = PH_LEN_HI;
            end else begin
                start_len = 1'b1;
                len_val   = {11'd0, b[4:0]};
            end
        end

        if (start_len) begin
            n_bin_rem = len_val;
            if (len_val == 16'd0) begin
                end_it = 1'b1;
            end else begin
                n_phase = PH_BIN_DATA;
            end
        end

        if (end_it) begin
            if (n_role == ROLE_TITLE) begin
                n_phase = PH_BIN_TAG;
                n_role  = ROLE_CONTENT;
            end else if (n_role == ROLE_CONTENT) begin
                n_phase = PH_MAP_HDR;
            end else if (n_role == ROLE_STAMP) begin
                n_phase = PH_DONE;
            end else begin
                fin = 1'b1;
            end
        end

        // one skipped object done: pop every level that runs out
        if (fin) begin
            if (found) begin
                n_level        = LW'(found_idx) + LW'(1);
                stk_ctl.pop_en = i_en;
                n_phase        = PH_SKIP;
                n_role         = ROLE_STRUCT;
            end else begin
                n_level = '0;
                after   = 1'b1;
            end
        end

        if (after) begin
            if (r_total == ARRAY_WITH_STAMP) begin
                n_phase = PH_BIN_TAG;
                n_role  = ROLE_STAMP;
            end else begin
                n_phase = PH_DONE;
            end
        end

        if (push) begin
            if (r_level >= LW'(NEST_DEPTH)) begin
                fail      = 1'b1;
                fail_code = ST_DEEP;
            end else begin
                stk_ctl.push_en = i_en;
                n_level         = r_level + LW'(1);
                n_phase         = PH_SKIP;
                n_role          = ROLE_STRUCT;
            end
        end

        if (fail) begin
            n_phase = PH_ERROR;
            n_err   = fail_code;
        end

        if (r_phase >= PH_ARR && r_phase <= PH_SKIP && r_count != 16'hFFFF) begin
            n_count = r_count + 16'd1;
        end
    end

    always_comb begin
        o_result                = '0;
        o_result.byte_value     = b;
        o_result.byte_role      = role;
        o_result.end_of_message = i_item.last_byte;
        if (i_item.last_byte) begin
            o_result.status         = (n_err != ST_OK) ? n_err :
                                      (n_phase != PH_DONE) ? ST_TRUNC : ST_OK;
            o_result.payload_length = n_count;
            o_result.map_no_entries = n_map_empty;
            o_result.stamp_present  = n_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_item.last_byte)) begin
            r_phase     <= PH_DEST;
            r_fix_idx   <= '0;
            r_role      <= ROLE_DEST;
            r_bin_rem   <= '0;
            r_len_hi    <= '0;
            r_total     <= '0;
            r_level     <= '0;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_map_empty <= 1'b0;
            r_stamp     <= 1'b0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_fix_idx   <= n_fix_idx;
            r_role      <= n_role;
            r_bin_rem   <= n_bin_rem;
            r_len_hi    <= n_len_hi;
            r_total     <= n_total;
            r_level     <= n_level;
            r_count     <= n_count;
            r_err       <= n_err;
            r_map_empty <= n_map_empty;
            r_stamp     <= n_stamp;
        end
    end

    mmd_skip_stack #(
        .NEST_DEPTH(NEST_DEPTH)
    ) u_skip_stack (
        .i_clk       (i_clk),
        .i_ctl       (stk_ctl),
        .i_level     (r_level),
        .i_push_value(push_val),
        .o_found     (found),
        .o_found_idx (found_idx)
    );

endmodule

### rtl/msgpack_message_deframer.sv
// msgpack_message_deframer: top level of the byte-stream message deframer
// input register, parse core and output register; uses mmd_pkg and mmd_parse_core
//
//   channel  direction  handshake            payload
//   in       to block   i_in_valid/o_in_stall  t_in_item  {data_byte, last_byte}
//   out      from block o_out_valid/i_out_stall t_out_item {byte, role, summary}
//
// one byte per cycle sustained while the output is not stalled; a taken byte goes
// through the input register, then the result register behind the parse logic
// the parser state advances only when a byte moves from the input register
// into the result register, so a stall on the output freezes it
// i_rst_n is synchronous and active low; it empties both registers and returns the
// parser to the destination hash; the end-of-message byte resets only the parser
// o_in_stall rises only while both registers hold a request and the output is stalled

module msgpack_message_deframer
    import mmd_pkg::*;
#(
    parameter int HASH_BYTES      = 16,
    parameter int SIGNATURE_BYTES = 64,
    parameter int NEST_DEPTH      = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item core_result;
    logic      adv;
    logic      accept_in;

    // input register hands over when the result register is free or draining
    assign adv        = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !adv;
    assign accept_in  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept_in) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1_item <= i_in_item;
        end
        if (adv) begin
            r_out_item <= core_result;
        end
    end

    // per-byte parse: role tag, state update and end-of-message summary
    mmd_parse_core #(
        .HASH_BYTES     (HASH_BYTES),
        .SIGNATURE_BYTES(SIGNATURE_BYTES),
        .NEST_DEPTH     (NEST_DEPTH)
    ) u_parse_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_item  (r_s1_item),
        .o_result(core_result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // summary fields stay zero except on the last byte
    a_summary_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.end_of_message) |->
        (o_out_item.status == ST_OK && o_out_item.payload_length == 16'd0
         && !o_out_item.map_no_entries && !o_out_item.stamp_present))
        else $error("summary field set on a byte that is not the last");

    // role codes stop at trailing
    a_role_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.byte_role <= ROLE_TRAIL))
        else $error("byte role out of range");

    // input stalls only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && r_s1_valid))
        else $error("input stalled without a stalled output");

    // a result moved out leaves the input register free the next cycle unless refilled
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !accept_in) |=> !r_s1_valid)
        else $error("input register not released after hand-over");

endmodule
